// File: src/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg: serial command frame receiver package
// Shared types and codes for the receiver front queue, engine and top level.
// ----------------------------------------------------------------------------
package scfr_pkg;

	localparam int ByteW   = 8;
	localparam int MagicW  = 24;
	localparam int WordW   = 32;
	localparam int EventW  = 3;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 24;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] CfgMagic   = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgLenCmd  = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgPayCmd  = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgIdleCmd = 2'd3;

	// result event codes
	localparam logic [EventW-1:0] EvNone    = 3'd0;
	localparam logic [EventW-1:0] EvCmd     = 3'd1;
	localparam logic [EventW-1:0] EvLenDone = 3'd2;
	localparam logic [EventW-1:0] EvByte    = 3'd3;
	localparam logic [EventW-1:0] EvPayDone = 3'd4;

	typedef struct packed {
		logic [MagicW-1:0] magic_word;
		logic [ByteW-1:0]  length_command;
		logic [ByteW-1:0]  payload_command;
		logic [ByteW-1:0]  idle_command;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
	} q_word_t;

	typedef struct packed {
		logic [EventW-1:0] event_res;
		logic [ByteW-1:0]  command_code;
		logic [WordW-1:0]  task_length;
		logic [ByteW-1:0]  data_byte;
		logic [WordW-1:0]  write_offset;
		logic              last;
	} res_t;

endpackage

// File: src/scfr_queue.sv
// ----------------------------------------------------------------------------
// scfr_queue: receive byte queue
// Front side: accepts received bytes and holds them for the frame engine.
// ----------------------------------------------------------------------------
module scfr_queue #(
	parameter int DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [scfr_pkg::ByteW-1:0] push_data,
	input  logic                      pop,
	output logic                      full,
	output scfr_pkg::q_word_t         head,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import scfr_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH+1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH-1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [ByteW-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FullCnt);
	assign do_push = push && !full;
	assign do_pop  = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/scfr_engine.sv
// ----------------------------------------------------------------------------
// scfr_engine: frame engine
// Back side: hunts for command and magic, gathers the length, passes payload.
// ----------------------------------------------------------------------------
module scfr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  scfr_pkg::cfg_t    cfg,
	input  scfr_pkg::q_word_t head,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output scfr_pkg::res_t    res
);
	import scfr_pkg::*;

	localparam logic [1:0] PhHunt    = 2'd0;
	localparam logic [1:0] PhLength  = 2'd1;
	localparam logic [1:0] PhPayload = 2'd2;
	localparam logic [2:0] WordBytes = 3'd4;

	logic [1:0]       phase_q;
	logic [WordW-1:0] hunt_word_q;
	logic [2:0]       hunt_left_q;
	logic [WordW-1:0] len_asm_q;
	logic [WordW-1:0] stored_len_q;
	logic [WordW-1:0] byte_cnt_q;
	logic             out_valid_q;
	res_t             res_q;

	logic [1:0]       phase_n;
	logic [WordW-1:0] hunt_word_n;
	logic [2:0]       hunt_left_n;
	logic [WordW-1:0] len_asm_n;
	logic [WordW-1:0] stored_len_n;
	logic [WordW-1:0] byte_cnt_n;
	res_t             res_n;

	logic [2:0]       left;
	logic [2:0]       left_dec;
	logic [WordW-1:0] word_fill;
	logic [WordW-1:0] cnt_inc;
	logic [ByteW-1:0] cmd;

	assign pop       = head.valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign cnt_inc   = byte_cnt_q + 1'b1;
	assign cmd       = word_fill[WordW-1 -: ByteW];

	always_comb begin
		left = hunt_left_q;
		if (left == 3'd0 || left > WordBytes) begin
			left = WordBytes;
		end
		left_dec = left - 1'b1;
		case (left_dec[1:0])
			2'd3:    word_fill = hunt_word_q | {head.data, 24'd0};
			2'd2:    word_fill = hunt_word_q | {8'd0, head.data, 16'd0};
			2'd1:    word_fill = hunt_word_q | {16'd0, head.data, 8'd0};
			default: word_fill = hunt_word_q | {24'd0, head.data};
		endcase
	end

	always_comb begin
		phase_n      = phase_q;
		hunt_word_n  = hunt_word_q;
		hunt_left_n  = hunt_left_q;
		len_asm_n    = len_asm_q;
		stored_len_n = stored_len_q;
		byte_cnt_n   = byte_cnt_q;
		res_n        = '0;
		res_n.event_res = EvNone;
		case (phase_q)
			PhLength: begin
				len_asm_n  = {len_asm_q[WordW-ByteW-1:0], head.data};
				byte_cnt_n = cnt_inc;
				if (cnt_inc >= WordW'(WordBytes)) begin
					stored_len_n      = len_asm_n;
					res_n.task_length = len_asm_n;
					res_n.event_res   = EvLenDone;
					len_asm_n         = '0;
					byte_cnt_n        = '0;
					phase_n           = PhHunt;
				end
			end
			PhPayload: begin
				res_n.data_byte    = head.data;
				res_n.write_offset = byte_cnt_q;
				byte_cnt_n         = cnt_inc;
				if (cnt_inc == stored_len_q) begin
					res_n.event_res = EvPayDone;
					res_n.last      = 1'b1;
					byte_cnt_n      = '0;
					phase_n         = PhHunt;
				end else begin
					res_n.event_res = EvByte;
				end
			end
			default: begin
				hunt_word_n = word_fill;
				hunt_left_n = left_dec;
				if (word_fill[MagicW-1:0] == cfg.magic_word) begin
					res_n.command_code = cmd;
					res_n.event_res    = EvCmd;
					hunt_word_n        = '0;
					hunt_left_n        = WordBytes;
					phase_n            = PhHunt;
					if (cmd == cfg.idle_command) begin
						phase_n = PhHunt;
					end else if (cmd == cfg.length_command) begin
						phase_n    = PhLength;
						len_asm_n  = '0;
						byte_cnt_n = '0;
					end else if (cmd == cfg.payload_command && stored_len_q != '0) begin
						phase_n    = PhPayload;
						byte_cnt_n = '0;
					end
				end
				if (hunt_left_n == 3'd0) begin
					hunt_word_n = '0;
					hunt_left_n = WordBytes;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PhHunt;
			hunt_word_q  <= '0;
			hunt_left_q  <= WordBytes;
			len_asm_q    <= '0;
			stored_len_q <= '0;
			byte_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q      <= phase_n;
				hunt_word_q  <= hunt_word_n;
				hunt_left_q  <= hunt_left_n;
				len_asm_q    <= len_asm_n;
				stored_len_q <= stored_len_n;
				byte_cnt_q   <= byte_cnt_n;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

endmodule

// File: src/serial_command_frame_receiver_top.sv
// Serial command frame receiver. Takes one received byte per cycle while
// in_stall is low and gives exactly one result word per byte, in order. A
// byte enters a queue of QUEUE_DEPTH words; the frame engine takes one byte
// per cycle from its head while the output is not stalled and writes its
// result into an output register, so the sustained rate is one byte per
// clock, set by the frame engine. A byte passes through the queue storage and
// then the output register. Stalls on the output fill the queue, and in_stall
// rises once it holds QUEUE_DEPTH bytes. Registers are written through the
// cfg port, which is always ready; write them only while no byte is in flight.
// ----------------------------------------------------------------------------
// serial_command_frame_receiver_top: serial command frame receiver
// Configuration registers, receive queue and frame engine.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [scfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [scfr_pkg::CfgW-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [scfr_pkg::ByteW-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [scfr_pkg::EventW-1:0]   event_res,
	output logic [scfr_pkg::ByteW-1:0]    command_code,
	output logic [scfr_pkg::WordW-1:0]    task_length,
	output logic [scfr_pkg::ByteW-1:0]    data_byte,
	output logic [scfr_pkg::WordW-1:0]    write_offset,
	output logic                          last
);
	import scfr_pkg::*;

	localparam int CntW = $clog2(QUEUE_DEPTH+1);

	cfg_t            cfg_q;
	q_word_t         head;
	res_t            res;
	logic            pop;
	logic [CntW-1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word      <= '0;
			cfg_q.length_command  <= 8'd1;
			cfg_q.payload_command <= 8'd2;
			cfg_q.idle_command    <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgMagic:   cfg_q.magic_word      <= cfg_data[MagicW-1:0];
				CfgLenCmd:  cfg_q.length_command  <= cfg_data[ByteW-1:0];
				CfgPayCmd:  cfg_q.payload_command <= cfg_data[ByteW-1:0];
				CfgIdleCmd: cfg_q.idle_command    <= cfg_data[ByteW-1:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	scfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_data(rx_byte),
		.pop      (pop),
		.full     (in_stall),
		.head     (head),
		.count    (q_count)
	);

	scfr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.res      (res)
	);

	assign event_res    = res.event_res;
	assign command_code = res.command_code;
	assign task_length  = res.task_length;
	assign data_byte    = res.data_byte;
	assign write_offset = res.write_offset;
	assign last         = res.last;

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CntW'(QUEUE_DEPTH))
		else $error("receive queue count beyond depth");

	a_pop_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("frame engine took a byte from an empty queue");

	a_last_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (event_res == EvPayDone)))
		else $error("last flag disagrees with payload done event");

	a_cmd_only_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EvCmd |-> command_code == '0)
		else $error("command code shown without a command event");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: serial command frame receiver
// Drives received bytes through the valid/stall channel, with random gaps and
// output stalls, and tracks the frame state (hunt, length, payload) itself to
// predict every result word. The stimulus opens with directed frames and then
// runs random phases, each under a fresh register setting, mostly of
// well-formed command frames with random content mixed with noise and broken
// frames.
// ----------------------------------------------------------------------------
module testbench;
	import scfr_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int PhaseBytes    = 215;
	localparam int MaxPayload    = 64;

	typedef enum logic [1:0] {
		PhHunt    = 2'd0,
		PhLength  = 2'd1,
		PhPayload = 2'd2
	} rx_phase_e;

	class frame_tracker;
		cfg_t             regs;
		rx_phase_e        phase;
		logic [WordW-1:0] hunt_word;
		logic [2:0]       hunt_left;
		logic [WordW-1:0] len_acc;
		logic [WordW-1:0] stored_len;
		logic [WordW-1:0] byte_cnt;
		res_t             expected_words[$];
		int               errors;

		function new();
			regs = '{magic_word: '0, length_command: 8'd1, payload_command: 8'd2,
				idle_command: 8'd0};
			phase      = PhHunt;
			hunt_word  = '0;
			hunt_left  = 3'd4;
			len_acc    = '0;
			stored_len = '0;
			byte_cnt   = '0;
			errors     = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
			case (idx)
				CfgMagic:   regs.magic_word      = value[MagicW-1:0];
				CfgLenCmd:  regs.length_command  = value[ByteW-1:0];
				CfgPayCmd:  regs.payload_command = value[ByteW-1:0];
				CfgIdleCmd: regs.idle_command    = value[ByteW-1:0];
			endcase
		endfunction

		function void clear_hunt();
			hunt_word = '0;
			hunt_left = 3'd4;
		endfunction

		// advance the frame state by one byte and queue the word it causes
		function logic [EventW-1:0] note_byte(logic [ByteW-1:0] b);
			res_t             r;
			logic [2:0]       left;
			logic [ByteW-1:0] c;
			r = '0;
			case (phase)
				PhLength: begin
					len_acc = {len_acc[WordW-9:0], b};
					byte_cnt++;
					if (byte_cnt >= 4) begin
						stored_len    = len_acc;
						r.task_length = len_acc;
						r.event_res   = EvLenDone;
						len_acc       = '0;
						byte_cnt      = '0;
						phase         = PhHunt;
					end
				end
				PhPayload: begin
					r.data_byte    = b;
					r.write_offset = byte_cnt;
					byte_cnt++;
					if (byte_cnt == stored_len) begin
						r.event_res = EvPayDone;
						r.last      = 1'b1;
						byte_cnt    = '0;
						phase       = PhHunt;
					end else begin
						r.event_res = EvByte;
					end
				end
				default: begin
					left = hunt_left;
					if (left == 3'd0 || left > 3'd4)
						left = 3'd4;
					left--;
					hunt_left = left;
					hunt_word = hunt_word | ({24'd0, b} << (8 * left));
					if (hunt_word[MagicW-1:0] == regs.magic_word) begin
						c              = hunt_word[WordW-1:MagicW];
						r.event_res    = EvCmd;
						r.command_code = c;
						clear_hunt();
						if (c == regs.idle_command) begin
							phase = PhHunt;
						end else if (c == regs.length_command) begin
							phase    = PhLength;
							len_acc  = '0;
							byte_cnt = '0;
						end else if (c == regs.payload_command && stored_len != 0) begin
							phase    = PhPayload;
							byte_cnt = '0;
						end else begin
							phase = PhHunt;
						end
					end
					if (hunt_left == 3'd0)
						clear_hunt();
				end
			endcase
			expected_words.push_back(r);
			return r.event_res;
		endfunction

		function string fmt(res_t r);
			return $sformatf("ev %0d cmd %h len %h data %h off %h last %b", r.event_res,
				r.command_code, r.task_length, r.data_byte, r.write_offset, r.last);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void check_word(res_t got);
			res_t want;
			if (expected_words.size() == 0) begin
				flag({"unexpected word: ", fmt(got)});
				return;
			end
			want = expected_words.pop_front();
			if (got.event_res !== want.event_res || got.command_code !== want.command_code ||
				got.task_length !== want.task_length || got.data_byte !== want.data_byte ||
				got.write_offset !== want.write_offset || got.last !== want.last)
				flag({"mismatch: expected ", fmt(want), ", got ", fmt(got)});
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgW-1:0]     cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [ByteW-1:0]    rx_byte;
	logic                out_valid;
	logic                out_stall;
	logic [EventW-1:0]   event_res;
	logic [ByteW-1:0]    command_code;
	logic [WordW-1:0]    task_length;
	logic [ByteW-1:0]    data_byte;
	logic [WordW-1:0]    write_offset;
	logic                last;

	frame_tracker     sb;
	res_t             out_word;
	bit               quiet;
	int               sent_bytes;
	int               stuck_cycles;
	logic [WordW-1:0] len_plan;

	serial_command_frame_receiver_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.command_code (command_code),
		.task_length  (task_length),
		.data_byte    (data_byte),
		.write_offset (write_offset),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always_comb begin
		out_word = '{event_res: event_res, command_code: command_code,
			task_length: task_length, data_byte: data_byte,
			write_offset: write_offset, last: last};
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(out_word);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WatchdogLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int wait_cycles();
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	// hold off result words at random
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = wait_cycles();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [ByteW-1:0] b, output logic [EventW-1:0] ev);
		int gap;
		gap = wait_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		ev = sb.note_byte(b);
		sent_bytes++;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		logic [CfgIdxW-1:0] order [4];
		logic [CfgW-1:0]    value;
		order = '{CfgMagic, CfgLenCmd, CfgPayCmd, CfgIdleCmd};
		foreach (order[i]) begin
			case (order[i])
				CfgMagic:   value = c.magic_word;
				CfgLenCmd:  value = CfgW'(c.length_command);
				CfgPayCmd:  value = CfgW'(c.payload_command);
				CfgIdleCmd: value = CfgW'(c.idle_command);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= value;
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(order[i], value);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t pick_cfg(int p);
		cfg_t c;
		case (p)
			0: c = '{magic_word: 24'hFFFFFF, length_command: 8'hFF, payload_command: 8'h00,
				idle_command: 8'h01};
			1: c = '{magic_word: 24'h000000, length_command: 8'h00, payload_command: 8'hFF,
				idle_command: 8'hFE};
			default: begin
				case ($urandom_range(0, 4))
					0: c.magic_word = '0;
					1: c.magic_word = '1;
					2: c.magic_word = {8'($urandom), 16'h0};
					3: c.magic_word = {16'($urandom), 8'h0};
					default: c.magic_word = 24'($urandom);
				endcase
				c.length_command  = 8'($urandom);
				c.payload_command = 8'($urandom);
				c.idle_command    = 8'($urandom);
				case ($urandom_range(0, 5))
					0: c.payload_command = c.length_command;
					1: c.idle_command = c.length_command;
					2: c.idle_command = c.payload_command;
					default: ;
				endcase
			end
		endcase
		return c;
	endfunction

	// realign to a word boundary, then send up to n_bytes of a command frame
	task automatic send_frame(input logic [ByteW-1:0] c, input int n_bytes,
		input logic [WordW-1:0] flip);
		logic [WordW-1:0]  w;
		logic [EventW-1:0] ev;
		while (sb.phase == PhHunt && sb.hunt_left != 3'd4)
			send_byte(8'($urandom), ev);
		w  = {c, sb.regs.magic_word} ^ flip;
		ev = EvNone;
		for (int i = 0; i < n_bytes; i++) begin
			if (sb.phase != PhHunt || ev == EvCmd)
				break;
			send_byte(w[WordW-1-8*i -: 8], ev);
		end
	endtask

	function automatic logic [WordW-1:0] pick_length();
		case ($urandom_range(0, 15))
			0: return '0;
			1, 2: return $urandom;
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	function automatic logic [ByteW-1:0] pick_command();
		case ($urandom_range(0, 7))
			0, 1, 2: return sb.regs.length_command;
			3, 4, 5: return sb.regs.payload_command;
			6: return sb.regs.idle_command;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_step();
		logic [EventW-1:0] ev;
		int                r;
		case (sb.phase)
			PhLength: begin
				if (sb.byte_cnt == 0)
					len_plan = pick_length();
				send_byte(8'(len_plan >> (8 * (3 - sb.byte_cnt))), ev);
			end
			PhPayload: send_byte(8'($urandom), ev);
			default: begin
				// drop a long stored length before a payload command can start it
				if (sb.stored_len > MaxPayload) begin
					send_frame(sb.regs.length_command, 4, '0);
				end else begin
					r = $urandom_range(0, 19);
					if (r < 12)
						send_frame(pick_command(), 4, '0);
					else if (r < 17)
						send_byte(8'($urandom), ev);
					else if (r < 19)
						send_frame(pick_command(), $urandom_range(1, 3), '0);
					else
						send_frame(pick_command(), 4,
							WordW'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
				end
			end
		endcase
	endtask

	initial begin
		logic [EventW-1:0] ev;
		logic [ByteW-1:0]  opening [$];
		logic [ByteW-1:0]  overlap [$];
		int                quota;
		bit                paused;
		sb           = new();
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		rx_byte      = '0;
		stuck_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero magic: every aligned byte is a command
		opening = '{8'hFF, 8'h00, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
			8'h01, 8'h00, 8'h00, 8'h00, 8'h03, 8'h02, 8'hFF, 8'h00, 8'hA5};
		foreach (opening[i])
			send_byte(opening[i], ev);

		wait_results_drained();
		program_regs('{magic_word: 24'h123456, length_command: 8'h5A,
			payload_command: 8'h5A, idle_command: 8'h5A});
		overlap = '{8'h5A, 8'h12, 8'h34, 8'h56};
		foreach (overlap[i])
			send_byte(overlap[i], ev);

		for (int p = 0; p < 8; p++) begin
			wait_results_drained();
			program_regs(pick_cfg(p));
			quota  = sent_bytes + PhaseBytes;
			paused = 1'b0;
			while (sent_bytes < quota || sb.stored_len > MaxPayload) begin
				if ($urandom_range(0, 63) == 0)
					quiet = !quiet;
				if (!paused && sent_bytes >= quota - 100) begin
					wait_results_drained();
					paused = 1'b1;
				end
				random_step();
			end
		end

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
